### rtl/core/rks_pkg.sv
// rks_pkg: shared constants and controller/datapath request types for the
// revision keyword scanner. No dependencies.
`default_nettype none

package rks_pkg;

  // candidate buffer size in bytes, including the opening and closing dollar
  localparam int MAX_KEYWORD_LEN = 64;
  localparam int ADDR_W          = $clog2(MAX_KEYWORD_LEN);
  localparam int LEN_W           = $clog2(MAX_KEYWORD_LEN + 1);

  // characters that steer the parser
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;

  // requests from the controller to the datapath
  typedef struct packed {
    logic accept;     // an input request is taken this cycle
    logic eof;        // the taken request is an end-of-file marker
    logic rd_en;      // read the keyword buffer at the emit index
    logic load_byte;  // move the read byte into the output register
  } rks_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic hit;        // current byte closes a valid keyword
    logic rd_last;    // emit index points at the last keyword byte
  } rks_sts_t;

endpackage

`default_nettype wire

### rtl/core/rks_datapath.sv
// rks_datapath: keyword parser state, candidate byte buffer, emit index and
// output payload register. Depends on rks_pkg.
`default_nettype none

module rks_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rks_pkg::rks_cmd_t cmd,
  input  wire logic [7:0]       data_byte,
  output rks_pkg::rks_sts_t     sts,
  output logic [7:0]            out_byte,
  output logic                  out_last,
  output logic                  out_sum,
  output logic                  out_had
);
  import rks_pkg::*;

  typedef enum logic [2:0] {
    P_IDLE,
    P_DOLLAR,
    P_WORD,
    P_COLON,
    P_COLON2,
    P_TEXT
  } pstate_t;

  pstate_t           pstate, pstate_next;
  logic              dcm, dcm_next;
  logic [LEN_W-1:0]  len, len_next;
  logic              found_any;
  logic [7:0]        prev_byte;
  logic [ADDR_W-1:0] rd_idx;
  logic [7:0]        rd_data;
  logic [7:0]        mem [MAX_KEYWORD_LEN];

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              hit;
  logic              full;
  logic              is_letter;
  logic              is_ctl;
  logic              step;

  // byte classes
  assign is_letter = (data_byte >= 8'h41 && data_byte <= 8'h5a) ||
                     (data_byte >= 8'h61 && data_byte <= 8'h7a);
  assign is_ctl    = (data_byte < 8'h20) || (data_byte == 8'h7f);
  assign full      = (len == LEN_W'(MAX_KEYWORD_LEN));
  assign step      = cmd.accept && !cmd.eof;

  // parser next state; entry 0 stands for the opening dollar and is never stored
  always_comb begin
    pstate_next = pstate;
    dcm_next    = dcm;
    len_next    = len;
    wr_en       = 1'b0;
    wr_addr     = len[ADDR_W-1:0];
    hit         = 1'b0;
    case (pstate)
      P_IDLE: begin
        if (data_byte == CH_DOLLAR) pstate_next = P_DOLLAR;
      end
      P_DOLLAR: begin
        if (is_letter) begin
          wr_en       = 1'b1;
          wr_addr     = ADDR_W'(1);
          len_next    = LEN_W'(2);
          pstate_next = P_WORD;
        end else if (data_byte != CH_DOLLAR) begin
          pstate_next = P_IDLE;
        end
      end
      P_WORD: begin
        if (full) begin
          len_next    = '0;
          pstate_next = P_IDLE;
        end else begin
          wr_en    = 1'b1;
          len_next = len + LEN_W'(1);
          if (is_letter) begin
            pstate_next = P_WORD;
          end else if (data_byte == CH_COLON) begin
            pstate_next = P_COLON;
            dcm_next    = 1'b0;
          end else if (data_byte == CH_DOLLAR) begin
            pstate_next = P_DOLLAR;
          end else begin
            pstate_next = P_IDLE;
          end
        end
      end
      P_COLON, P_COLON2: begin
        if (full) begin
          len_next    = '0;
          pstate_next = P_IDLE;
        end else begin
          wr_en    = 1'b1;
          len_next = len + LEN_W'(1);
          if (data_byte == CH_COLON) begin
            if (pstate == P_COLON) begin
              pstate_next = P_COLON2;
              dcm_next    = 1'b1;
            end else begin
              pstate_next = P_IDLE;
            end
          end else if (data_byte == CH_SPACE) begin
            pstate_next = P_TEXT;
          end else begin
            pstate_next = P_IDLE;
          end
        end
      end
      P_TEXT: begin
        if (full) begin
          len_next    = '0;
          pstate_next = P_IDLE;
        end else begin
          wr_en    = 1'b1;
          len_next = len + LEN_W'(1);
          if (is_ctl) begin
            pstate_next = P_IDLE;
          end else if (data_byte == CH_DOLLAR) begin
            pstate_next = P_IDLE;
            hit = (prev_byte == CH_SPACE) || (dcm && (prev_byte == CH_HASH));
          end
        end
      end
      default: begin
        pstate_next = P_IDLE;
      end
    endcase
  end

  assign sts.hit     = hit;
  assign sts.rd_last = ((LEN_W'(rd_idx) + LEN_W'(1)) == len);

  // parser control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate    <= P_IDLE;
      dcm       <= 1'b0;
      len       <= '0;
      found_any <= 1'b0;
    end else if (cmd.accept) begin
      if (cmd.eof) begin
        pstate    <= P_IDLE;
        dcm       <= 1'b0;
        len       <= '0;
        found_any <= 1'b0;
      end else begin
        pstate <= pstate_next;
        dcm    <= dcm_next;
        len    <= len_next;
        if (hit) found_any <= 1'b1;
      end
    end
  end

  // keyword buffer write and registered read
  always_ff @(posedge clk) begin
    if (step && wr_en) mem[wr_addr] <= data_byte;
    if (cmd.rd_en) rd_data <= mem[rd_idx];
  end

  // last stored byte and emit index
  always_ff @(posedge clk) begin
    if (step && wr_en) prev_byte <= data_byte;
    if (step && hit) begin
      rd_idx <= '0;
    end else if (cmd.load_byte && !sts.rd_last) begin
      rd_idx <= rd_idx + ADDR_W'(1);
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (cmd.accept && cmd.eof) begin
      out_byte <= 8'h00;
      out_last <= 1'b1;
      out_sum  <= 1'b1;
      out_had  <= found_any;
    end else if (cmd.load_byte) begin
      out_byte <= (rd_idx == '0) ? CH_DOLLAR : rd_data;
      out_last <= sts.rd_last;
      out_sum  <= 1'b0;
      out_had  <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  // buffer length never exceeds its capacity
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(MAX_KEYWORD_LEN))
    else $error("keyword length beyond buffer");

  // a hit only happens with at least dollar, letter, colon, space, dollar
  a_hit_len: assert property (@(posedge clk) disable iff (rst)
    (step && hit) |-> (len >= LEN_W'(4)))
    else $error("keyword closed with too short a buffer");

  // summary clears the found flag and the buffer length
  a_eof_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && cmd.eof) |=> (!found_any && len == '0))
    else $error("summary did not clear scan state");
`endif

endmodule

`default_nettype wire

### rtl/core/rks_ctrl.sv
// rks_ctrl: handshake control and keyword emit sequencer for the keyword
// scanner. Depends on rks_pkg.
`default_nettype none

module rks_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic              s_tuser,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire rks_pkg::rks_sts_t sts,
  output rks_pkg::rks_cmd_t      cmd
);
  import rks_pkg::*;

  typedef enum logic [1:0] {
    C_SCAN,
    C_READ,
    C_LOAD
  } cstate_t;

  cstate_t state;
  logic    out_valid;
  logic    out_free;
  logic    take;

  // output slot is free or frees up this cycle
  assign out_free = !out_valid || m_tready;

  // plain bytes need no output slot, end-of-file needs one
  assign s_tready = (state == C_SCAN) && (out_free || !s_tuser);
  assign take     = s_tvalid && s_tready;
  assign m_tvalid = out_valid;

  assign cmd.accept    = take;
  assign cmd.eof       = s_tuser;
  assign cmd.rd_en     = (state == C_READ);
  assign cmd.load_byte = (state == C_LOAD) && out_free;

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_SCAN;
      out_valid <= 1'b0;
    end else begin
      case (state)
        C_SCAN: begin
          if (take && !s_tuser && sts.hit) state <= C_READ;
        end
        C_READ: begin
          state <= C_LOAD;
        end
        C_LOAD: begin
          if (out_free) state <= sts.rd_last ? C_SCAN : C_READ;
        end
        default: begin
          state <= C_SCAN;
        end
      endcase
      if ((take && s_tuser) || cmd.load_byte) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // a closing dollar starts the emit sequence
  a_hit_emit: assert property (@(posedge clk) disable iff (rst)
    (take && !s_tuser && sts.hit) |=> (state == C_READ))
    else $error("keyword hit did not start emit");

  // every buffer read is followed by a load attempt
  a_read_load: assert property (@(posedge clk) disable iff (rst)
    (state == C_READ) |=> (state == C_LOAD))
    else $error("buffer read not followed by load");

  // a loaded byte is presented on the output
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_byte |=> out_valid)
    else $error("loaded byte not presented");

  // the final keyword byte returns the sequencer to scanning
  a_last_scan: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_byte && sts.rd_last) |=> (state == C_SCAN))
    else $error("emit did not end on last byte");
`endif

endmodule

`default_nettype wire

### rtl/core/rcs_keyword_scanner.sv
// rcs_keyword_scanner: top level of the revision keyword scanner, joining the
// controller (rks_ctrl) and the datapath (rks_datapath). Depends on rks_pkg.
//
//   channel   dir  tdata              tuser                        tlast
//   s_*       in   [7:0] data_byte    [0] end_of_file              -
//   m_*       out  [7:0] out_byte     [0] is_summary [1] had_kw    last_of_run
//
// one input byte per cycle while scanning; a plain byte never waits on the
// output side, an end-of-file request waits for a free output register.
// a found keyword is emitted byte by byte, each byte a buffer read and then
// an output load that waits for a free output register; input is held off meanwhile.
// reset clears parser state, length, found flag and output valid; the byte
// buffer has no reset and only entries of the current candidate are read.
`default_nettype none

module rcs_keyword_scanner (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tuser,   // [0] end_of_file
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic [1:0]      m_tuser,   // [0] is_summary, [1] had_keyword
  output logic            m_tlast    // last_of_run
);
  import rks_pkg::*;

  rks_cmd_t cmd;
  rks_sts_t sts;
  logic     out_sum;
  logic     out_had;

  // handshake control and emit sequencing
  rks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // parser, buffer and output payload
  rks_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (s_tdata),
    .sts       (sts),
    .out_byte  (m_tdata),
    .out_last  (m_tlast),
    .out_sum   (out_sum),
    .out_had   (out_had)
  );

  assign m_tuser = {out_had, out_sum};

endmodule

`default_nettype wire
